[design/ple_pkg.sv]
// ----------------------------------------------------------------------------
// Positional list engine package
// Shared sizes, types, operation codes and status codes.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);

	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [CNT_W-1:0]      count_t;
	typedef logic [IDX_W-1:0]      idx_t;

	localparam logic [2:0] OP_INS_POS   = 3'd0;
	localparam logic [2:0] OP_INS_FRONT = 3'd1;
	localparam logic [2:0] OP_INS_BACK  = 3'd2;
	localparam logic [2:0] OP_DEL_POS   = 3'd3;
	localparam logic [2:0] OP_DEL_FRONT = 3'd4;
	localparam logic [2:0] OP_DEL_BACK  = 3'd5;
	localparam logic [2:0] OP_DUMP_FWD  = 3'd6;
	localparam logic [2:0] OP_DUMP_REV  = 3'd7;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	typedef struct packed {
		logic ins;
		logic del;
		logic hit;
		logic above;
	} cell_ctl_t;

endpackage

[design/ple_cell.sv]
// ----------------------------------------------------------------------------
// Positional list engine cell
// Holds one list entry and shifts toward either neighbor on insert or delete.
// ----------------------------------------------------------------------------
module ple_cell (
	input  logic               clk,
	input  ple_pkg::cell_ctl_t ctl,
	input  ple_pkg::data_t     new_data,
	input  ple_pkg::data_t     left_data,
	input  ple_pkg::data_t     right_data,
	output ple_pkg::data_t     data_q
);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (ctl.hit) begin
				data_q <= new_data;
			end else if (ctl.above) begin
				data_q <= left_data;
			end
		end else if (ctl.del) begin
			if (ctl.hit || ctl.above) begin
				data_q <= right_data;
			end
		end
	end

endmodule

[design/positional_list_engine.sv]
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list held in a row of shifting cells, with positional insert and
// delete and a forward or reverse dump of the whole list.
//
//   channel   direction   handshake            payload
//   in        input       in_valid / in_stall  op, value, position
//   out       output      out_valid / out_stall status, has_value, element,
//                                              entry_count, last
//
// An insert or delete is a registered update of all cells at once and gives
// one transaction the cycle after it is taken; one such operation can be
// taken every cycle while the output register drains. A dump gives one
// transaction per entry, one per cycle unless out_stall is high, read from
// the cells through the dump index; input is stalled until the last one is
// loaded. Reset empties the list at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module positional_list_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [31:0] value,
	input  logic [6:0]  position,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        has_value,
	output logic [31:0] element,
	output logic [6:0]  entry_count,
	output logic        last
);

	ple_pkg::data_t     cell_q [ple_pkg::DEPTH];
	ple_pkg::cell_ctl_t cell_ctl [ple_pkg::DEPTH];

	ple_pkg::count_t count_q;
	ple_pkg::count_t count_nxt;
	ple_pkg::count_t left_q;
	ple_pkg::idx_t   rd_idx_q;
	ple_pkg::idx_t   tgt_idx;
	logic            dump_q;
	logic            rev_q;
	logic            out_valid_q;
	logic            out_free;
	logic            acc;
	logic            do_ins;
	logic            do_del;
	logic            start_dump;
	logic [1:0]      status_c;
	logic [7:0]      pos8;
	logic [7:0]      cnt8;
	logic            is_full;
	logic            is_empty;

	logic [1:0]  status_q;
	logic        has_value_q;
	logic [31:0] element_q;
	logic [6:0]  entry_count_q;
	logic        last_q;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = dump_q || !out_free;
	assign acc      = in_valid && !in_stall;

	assign pos8     = {1'b0, position};
	assign cnt8     = 8'(count_q);
	assign is_full  = count_q == ple_pkg::count_t'(ple_pkg::DEPTH);
	assign is_empty = count_q == '0;

	always_comb begin
		status_c   = ple_pkg::ST_OK;
		do_ins     = 1'b0;
		do_del     = 1'b0;
		start_dump = 1'b0;
		tgt_idx    = '0;
		unique case (op)
			ple_pkg::OP_INS_POS: begin
				if (pos8 == 8'd0 || pos8 > cnt8 + 8'd1) begin
					status_c = ple_pkg::ST_BADPOS;
				end else if (is_full) begin
					status_c = ple_pkg::ST_FULL;
				end else begin
					do_ins  = 1'b1;
					tgt_idx = ple_pkg::idx_t'(pos8 - 8'd1);
				end
			end
			ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK: begin
				if (is_full) begin
					status_c = ple_pkg::ST_FULL;
				end else begin
					do_ins  = 1'b1;
					tgt_idx = (op == ple_pkg::OP_INS_FRONT) ? '0 : ple_pkg::idx_t'(count_q);
				end
			end
			ple_pkg::OP_DEL_POS: begin
				if (pos8 == 8'd0 || pos8 > cnt8) begin
					status_c = ple_pkg::ST_BADPOS;
				end else begin
					do_del  = 1'b1;
					tgt_idx = ple_pkg::idx_t'(pos8 - 8'd1);
				end
			end
			ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK: begin
				if (is_empty) begin
					status_c = ple_pkg::ST_EMPTY;
				end else begin
					do_del  = 1'b1;
					tgt_idx = (op == ple_pkg::OP_DEL_FRONT) ? '0
						: ple_pkg::idx_t'(count_q - 1'b1);
				end
			end
			ple_pkg::OP_DUMP_FWD, ple_pkg::OP_DUMP_REV: begin
				if (is_empty) begin
					status_c = ple_pkg::ST_EMPTY;
				end else begin
					start_dump = 1'b1;
				end
			end
		endcase
	end

	always_comb begin
		count_nxt = count_q;
		if (do_ins) begin
			count_nxt = count_q + 1'b1;
		end else if (do_del) begin
			count_nxt = count_q - 1'b1;
		end
	end

	for (genvar k = 0; k < ple_pkg::DEPTH; k++) begin : g_cell
		assign cell_ctl[k] = '{
			ins:   acc && do_ins,
			del:   acc && do_del,
			hit:   ple_pkg::idx_t'(k) == tgt_idx,
			above: ple_pkg::idx_t'(k) > tgt_idx
		};
		if (k == 0) begin : g_head
			ple_cell u_cell (
				.clk        (clk),
				.ctl        (cell_ctl[k]),
				.new_data   (ple_pkg::data_t'(value)),
				.left_data  ('0),
				.right_data (cell_q[k+1]),
				.data_q     (cell_q[k])
			);
		end else if (k == ple_pkg::DEPTH - 1) begin : g_tail
			ple_cell u_cell (
				.clk        (clk),
				.ctl        (cell_ctl[k]),
				.new_data   (ple_pkg::data_t'(value)),
				.left_data  (cell_q[k-1]),
				.right_data ('0),
				.data_q     (cell_q[k])
			);
		end else begin : g_mid
			ple_cell u_cell (
				.clk        (clk),
				.ctl        (cell_ctl[k]),
				.new_data   (ple_pkg::data_t'(value)),
				.left_data  (cell_q[k-1]),
				.right_data (cell_q[k+1]),
				.data_q     (cell_q[k])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			dump_q      <= 1'b0;
			count_q     <= '0;
		end else begin
			if (dump_q && out_free) begin
				out_valid_q <= 1'b1;
				if (left_q == ple_pkg::count_t'(1)) begin
					dump_q <= 1'b0;
				end
			end else if (acc && !start_dump) begin
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
			if (acc) begin
				count_q <= count_nxt;
				if (start_dump) begin
					dump_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dump_q && out_free) begin
			status_q      <= ple_pkg::ST_OK;
			has_value_q   <= 1'b1;
			element_q     <= 32'(cell_q[rd_idx_q]);
			entry_count_q <= 7'(count_q);
			last_q        <= left_q == ple_pkg::count_t'(1);
			left_q        <= left_q - 1'b1;
			rd_idx_q      <= rev_q ? rd_idx_q - 1'b1 : rd_idx_q + 1'b1;
		end else if (acc) begin
			if (start_dump) begin
				rev_q    <= op == ple_pkg::OP_DUMP_REV;
				left_q   <= count_q;
				rd_idx_q <= (op == ple_pkg::OP_DUMP_REV) ? ple_pkg::idx_t'(count_q - 1'b1) : '0;
			end else begin
				status_q      <= status_c;
				has_value_q   <= 1'b0;
				element_q     <= '0;
				entry_count_q <= 7'(count_nxt);
				last_q        <= 1'b1;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign has_value   = has_value_q;
	assign element     = element_q;
	assign entry_count = entry_count_q;
	assign last        = last_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ple_pkg::count_t'(ple_pkg::DEPTH))
		else $error("List count exceeds capacity.");

	a_dump_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		dump_q |-> in_stall)
		else $error("Input taken during a dump.");

	a_dump_ends: assert property (@(posedge clk) disable iff (!arst_n)
		dump_q && out_free && left_q == ple_pkg::count_t'(1) |=> !dump_q && out_valid && last)
		else $error("Dump did not end on its final transaction.");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		acc && do_ins |=> count_q == ple_pkg::count_t'($past(count_q) + 1'b1))
		else $error("Insert did not grow the list by one.");

	a_delete_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		acc && do_del |=> count_q == ple_pkg::count_t'($past(count_q) - 1'b1))
		else $error("Delete did not shrink the list by one.");
`endif

endmodule
